@@ rtl/bie_pkg.sv @@
// ----------------------------------------------------------------------------
// bie_pkg
// Shared types and constants for the bytecode instruction executor.
// ----------------------------------------------------------------------------
package bie_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int DATA_W    = 32;
    localparam int PC_BITS   = 16;
    localparam int NEXT_PC_W = 16;
    localparam int OP_W      = 3;
    localparam int EV_W      = 3;
    localparam int STR_W     = 5;

    typedef enum logic [OP_W-1:0] {
        OP_END       = 3'd0,
        OP_PRINT_STR = 3'd1,
        OP_PRINT_INT = 3'd2,
        OP_SET_IMM   = 3'd3,
        OP_BRANCH_NZ = 3'd4,
        OP_SUB       = 3'd5
    } t_op;

    typedef enum logic [EV_W-1:0] {
        EV_NONE      = 3'd0,
        EV_PRINT_INT = 3'd1,
        EV_PRINT_STR = 3'd2,
        EV_HALT      = 3'd3,
        EV_ILLEGAL   = 3'd4
    } t_event;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr0;
        logic [REG_IDX_W-1:0] addr1;
    } t_rd_req;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [DATA_W-1:0]    data;
    } t_wr_req;

endpackage

@@ rtl/bie_regfile.sv @@
// ----------------------------------------------------------------------------
// bie_regfile
// Register file memory: two registered read ports, one write port, per-entry
// valid bits so that never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
module bie_regfile
    import bie_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rd_req           i_rd,
    input  t_wr_req           i_wr,
    output logic [DATA_W-1:0] o_rd_data0,
    output logic [DATA_W-1:0] o_rd_data1
);

    logic [DATA_W-1:0]    mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [DATA_W-1:0]    r_q0;
    logic [DATA_W-1:0]    r_q1;
    logic                 r_v0;
    logic                 r_v1;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_q0 <= mem[i_rd.addr0];
            r_q1 <= mem[i_rd.addr1];
            r_v0 <= r_vld[i_rd.addr0];
            r_v1 <= r_vld[i_rd.addr1];
        end
    end

    assign o_rd_data0 = r_v0 ? r_q0 : '0;
    assign o_rd_data1 = r_v1 ? r_q1 : '0;

endmodule

@@ rtl/bie_exec.sv @@
// ----------------------------------------------------------------------------
// bie_exec
// Execute stage: operand forwarding, subtract/compare, pc update,
// register write-back and the output register.
// ----------------------------------------------------------------------------
module bie_exec
    import bie_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [REG_IDX_W-1:0]     i_first_operand,
    input  logic signed [DATA_W-1:0] i_second_operand,
    input  logic [REG_IDX_W-1:0]     i_third_operand,
    input  logic [REG_IDX_W-1:0]     i_rd_addr0,
    input  logic [DATA_W-1:0]        i_rd_data0,
    input  logic [DATA_W-1:0]        i_rd_data1,
    output logic                     o_accept,
    output t_wr_req                  o_wr,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [NEXT_PC_W-1:0]     o_next_pc,
    output logic [EV_W-1:0]          o_event_kind,
    output logic signed [DATA_W-1:0] o_print_value,
    output logic [STR_W-1:0]         o_string_index
);

    logic                 r_s1_valid;
    t_op                  r_op;
    logic [REG_IDX_W-1:0] r_a;
    logic [DATA_W-1:0]    r_b;
    logic [REG_IDX_W-1:0] r_ra0;
    logic [REG_IDX_W-1:0] r_ra1;

    logic                 r_fwd_valid;
    logic [REG_IDX_W-1:0] r_fwd_idx;
    logic [DATA_W-1:0]    r_fwd_data;

    logic [PC_BITS-1:0]   r_pc;
    logic [PC_BITS-1:0]   n_pc;

    logic                 r_out_valid;
    logic [NEXT_PC_W-1:0] r_out_pc;
    t_event               r_out_ev;
    logic [DATA_W-1:0]    r_out_pval;
    logic [STR_W-1:0]     r_out_sidx;

    t_event               n_ev;
    logic [DATA_W-1:0]    n_pval;
    logic [STR_W-1:0]     n_sidx;
    logic                 n_we;
    logic [DATA_W-1:0]    n_wdata;

    logic                 s1_adv;
    logic [DATA_W-1:0]    opd0;
    logic [DATA_W-1:0]    opd1;

    assign s1_adv   = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_s1_valid && !s1_adv;
    assign o_accept = i_valid && !o_stall;

    // last write-back lands in the memory at the same edge as the read
    assign opd0 = (r_fwd_valid && r_fwd_idx == r_ra0) ? r_fwd_data : i_rd_data0;
    assign opd1 = (r_fwd_valid && r_fwd_idx == r_ra1) ? r_fwd_data : i_rd_data1;

    always_comb begin
        n_pc    = r_pc;
        n_ev    = EV_NONE;
        n_pval  = '0;
        n_sidx  = '0;
        n_we    = 1'b0;
        n_wdata = opd0 - opd1;
        case (r_op)
            OP_END: begin
                n_ev = EV_HALT;
            end
            OP_PRINT_STR: begin
                n_ev   = EV_PRINT_STR;
                n_sidx = STR_W'(r_a);
                n_pc   = r_pc + PC_BITS'(2);
            end
            OP_PRINT_INT: begin
                n_ev   = EV_PRINT_INT;
                n_pval = opd0;
                n_pc   = r_pc + PC_BITS'(2);
            end
            OP_SET_IMM: begin
                n_we    = 1'b1;
                n_wdata = r_b;
                n_pc    = r_pc + PC_BITS'(3);
            end
            OP_BRANCH_NZ: begin
                if (opd0 != '0) begin
                    n_pc = r_pc + r_b[PC_BITS-1:0];
                end else begin
                    n_pc = r_pc + PC_BITS'(3);
                end
            end
            OP_SUB: begin
                n_we = 1'b1;
                n_pc = r_pc + PC_BITS'(4);
            end
            default: begin
                n_ev = EV_ILLEGAL;
            end
        endcase
    end

    assign o_wr.en   = s1_adv && n_we;
    assign o_wr.addr = r_a;
    assign o_wr.data = n_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && n_we) begin
                r_fwd_valid <= 1'b1;
            end
            if (s1_adv) begin
                r_pc        <= n_pc;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_op  <= t_op'(i_operation);
            r_a   <= i_first_operand;
            r_b   <= i_second_operand;
            r_ra0 <= i_rd_addr0;
            r_ra1 <= i_third_operand;
        end
        if (s1_adv && n_we) begin
            r_fwd_idx  <= r_a;
            r_fwd_data <= n_wdata;
        end
        if (s1_adv) begin
            r_out_pc   <= NEXT_PC_W'(n_pc);
            r_out_ev   <= n_ev;
            r_out_pval <= n_pval;
            r_out_sidx <= n_sidx;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_next_pc      = r_out_pc;
    assign o_event_kind   = r_out_ev;
    assign o_print_value  = r_out_pval;
    assign o_string_index = r_out_sidx;

endmodule

@@ rtl/bytecode_instruction_executor_core.sv @@
// ----------------------------------------------------------------------------
// bytecode_instruction_executor_core
// Executes one decoded bytecode instruction per transaction against a
// 32 x 32-bit register file held in memory and a program counter.
//
//   channel   signals                                          direction
//   input     i_valid / o_stall, operation, three operands     in
//   output    o_valid / i_stall, next_pc, event, print data    out
//
// One transaction per cycle sustained while the output is not stalled; the result
// is registered by the memory read, then by execute into the output register.
// The last write-back is forwarded to the next instruction's operands.
// Reset clears the register-file valid bits, so all registers read as zero.
// A stalled output holds the execute stage, which then stalls the input.
// ----------------------------------------------------------------------------
module bytecode_instruction_executor_core
    import bie_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [REG_IDX_W-1:0]     i_first_operand,
    input  logic signed [DATA_W-1:0] i_second_operand,
    input  logic [REG_IDX_W-1:0]     i_third_operand,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [NEXT_PC_W-1:0]     o_next_pc,
    output logic [EV_W-1:0]          o_event_kind,
    output logic signed [DATA_W-1:0] o_print_value,
    output logic [STR_W-1:0]         o_string_index
);

    t_rd_req              rd_req;
    t_wr_req              wr_req;
    logic                 accept;
    logic [DATA_W-1:0]    rd_data0;
    logic [DATA_W-1:0]    rd_data1;

    // subtract reads its first source from the low bits of second_operand
    assign rd_req.en    = accept;
    assign rd_req.addr0 = (t_op'(i_operation) == OP_SUB) ?
                          i_second_operand[REG_IDX_W-1:0] : i_first_operand;
    assign rd_req.addr1 = i_third_operand;

    bie_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd       (rd_req),
        .i_wr       (wr_req),
        .o_rd_data0 (rd_data0),
        .o_rd_data1 (rd_data1)
    );

    bie_exec u_exec (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .i_third_operand  (i_third_operand),
        .i_rd_addr0       (rd_req.addr0),
        .i_rd_data0       (rd_data0),
        .i_rd_data1       (rd_data1),
        .o_accept         (accept),
        .o_wr             (wr_req),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_next_pc        (o_next_pc),
        .o_event_kind     (o_event_kind),
        .o_print_value    (o_print_value),
        .o_string_index   (o_string_index)
    );

endmodule
